// ===== hw/rtl/framebuffer_line_rect_engine_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the framebuffer engine RTL
// ---------------------------------------------------------------------------
`ifndef FRAMEBUFFER_LINE_RECT_ENGINE_TOP_DEFINES_SVH
`define FRAMEBUFFER_LINE_RECT_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property that holds while out of reset
`define FBRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next
`define FBRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBRE_ASSERT(lbl, prop, msg)
`define FBRE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/fbre_pkg.sv =====
// ---------------------------------------------------------------------------
// fbre_pkg
// Types and constants of the framebuffer line and rectangle engine.
// ---------------------------------------------------------------------------
package fbre_pkg;

    // Framebuffer geometry and slope unit
    localparam int FB_WIDTH   = 128;
    localparam int FB_HEIGHT  = 128;
    localparam int SLOPE_ONE  = 256;
    localparam int FB_DEPTH   = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W     = $clog2(FB_DEPTH);

    // Datapath widths
    localparam int COLOR_W    = 24;
    localparam int CALC_W     = 15;                       // signed setup math
    localparam int COORD_W    = 10;                       // absolute plot coords
    localparam int CNT_W      = 9;                        // pixel loop counters
    localparam int DEN_W      = 8;                        // divisor (line extent)
    localparam int SLP_W      = $clog2(SLOPE_ONE + 1);    // slope, up to SLOPE_ONE
    localparam int ACC_W      = SLP_W + 1;                // slope accumulator
    localparam int DVD_W      = DEN_W + SLP_W;            // extent * SLOPE_ONE
    localparam int CNTD_W     = $clog2(DVD_W + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 3'd5;

    // Command kinds
    typedef enum logic [1:0] {
        KIND_FILL  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_LINE  = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    // Command word
    typedef struct packed {
        t_kind              kind;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic signed [11:0] extent_w;
        logic signed [11:0] extent_h;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic [COLOR_W-1:0] pixel_value;
        logic               rejected;
    } t_res;

endpackage

// ===== hw/rtl/framebuffer_line_rect_engine_top.sv =====
// Accept to result: setup, the slope divider for a sloped line, then plotting (w*h
//   pixels for a rectangle, major-axis length for a line), then the result word.
// Pixel read: setup, RAM read, result; rejected commands skip straight to the result.
// Throughput: one command at a time, one pixel write per cycle; a held result stalls.
// Reset (sync, active low) clears control and restores clip/color registers;
//   the frame store is not cleared and reads undefined until written.
// ---------------------------------------------------------------------------
// framebuffer_line_rect_engine_top
// Rectangle fill/clear, line drawing and pixel read over a 24-bit framebuffer.
// ---------------------------------------------------------------------------
`include "framebuffer_line_rect_engine_top_defines.svh"

module framebuffer_line_rect_engine_top import fbre_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  t_cmd                 i_cmd,
    // result channel
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_res                 o_res,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_DIV   = 6'b000100,
        S_PLOT  = 6'b001000,
        S_RD    = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [6:0]         r_clip_left, r_clip_top;
    logic [7:0]         r_clip_w, r_clip_h;
    logic [COLOR_W-1:0] r_fg, r_bg;

    // command and loop state
    t_cmd               r_cmd;
    logic [COORD_W-1:0] r_x, r_y, r_x0;
    logic [CNT_W-1:0]   r_i, r_j, r_w, r_h;
    logic               r_line, r_maj_x, r_y_dn;
    logic [SLP_W-1:0]   r_slope;
    logic [ACC_W-1:0]   r_acc;
    logic [COLOR_W-1:0] r_color, r_pix;
    logic               r_rej;
    t_res               r_res;
    logic               r_res_valid;

    // ---------------- setup math (from the registered command) ----------------
    logic signed [CALC_W-1:0] c_x, c_y, c_w, c_h, c_cw, c_ch;
    logic signed [CALC_W-1:0] rx, ry, rw, rh, rcw, rch, rw2, rh2;
    logic signed [CALC_W-1:0] lx, ly, lw, lh, ex, ey, la;
    logic                     rect_rej, line_rej, rd_ok, neg, h0, w0, maj_y, need_div;
    logic [CNT_W-1:0]         line_n;
    logic [DEN_W-1:0]         div_num, div_den;

    assign c_x  = CALC_W'(r_cmd.pos_x);
    assign c_y  = CALC_W'(r_cmd.pos_y);
    assign c_w  = CALC_W'(r_cmd.extent_w);
    assign c_h  = CALC_W'(r_cmd.extent_h);
    assign c_cw = $signed({{(CALC_W-8){1'b0}}, r_clip_w});
    assign c_ch = $signed({{(CALC_W-8){1'b0}}, r_clip_h});

    // rectangle clip
    assign rx  = c_x[CALC_W-1] ? '0 : c_x;
    assign ry  = c_y[CALC_W-1] ? '0 : c_y;
    assign rw  = c_x[CALC_W-1] ? c_w + c_x : c_w;
    assign rh  = c_y[CALC_W-1] ? c_h + c_y : c_h;
    assign rcw = c_cw - rx;
    assign rch = c_ch - ry;
    assign rw2 = (rcw < rw) ? rcw : rw;
    assign rh2 = (rch < rh) ? rch : rh;
    assign rect_rej = (rx > c_cw) || (ry > c_ch) || rw2[CALC_W-1] || (rw2 == '0)
                   || rh2[CALC_W-1] || (rh2 == '0);

    // line: swap ends for a negative width, then reject
    assign neg = c_w[CALC_W-1];
    assign lx  = neg ? c_x + c_w : c_x;
    assign ly  = neg ? c_y + c_h : c_y;
    assign lw  = neg ? -c_w : c_w;
    assign lh  = neg ? -c_h : c_h;
    assign ex  = lx + lw;
    assign ey  = ly + lh;
    assign line_rej = lx[CALC_W-1] || ly[CALC_W-1] || (lx > c_cw) || (ly > c_ch)
                   || (ex >= c_cw) || (ey >= c_ch) || ey[CALC_W-1];
    assign la  = lh[CALC_W-1] ? -lh : lh;
    assign h0  = (lh == '0);
    assign w0  = (lw == '0);
    // major axis: y when steeper; at 45 degrees x up, y down
    assign maj_y    = !h0 && (w0 || (la > lw) || (lh[CALC_W-1] && (la == lw)));
    assign need_div = !h0 && !w0;
    assign line_n   = h0 ? (w0 ? CNT_W'(1) : CNT_W'(lw)) : (maj_y ? CNT_W'(la) : CNT_W'(lw));
    assign div_num  = maj_y ? DEN_W'(lw) : DEN_W'(la);
    assign div_den  = maj_y ? DEN_W'(la) : DEN_W'(lw);

    // pixel read bounds
    assign rd_ok = !c_x[CALC_W-1] && !c_y[CALC_W-1] && (c_x < FB_WIDTH) && (c_y < FB_HEIGHT);

    // ---------------- divider ----------------
    logic             w_div_start, w_div_done;
    logic [SLP_W-1:0] w_quo;

    assign w_div_start = (r_state == S_SETUP) && (r_cmd.kind == KIND_LINE)
                      && !line_rej && need_div;

    fbre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (DVD_W'(div_num) * DVD_W'(SLOPE_ONE)),
        .i_den   (div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // ---------------- frame store ----------------
    logic               w_we, w_re;
    logic [ADDR_W-1:0]  w_waddr, w_raddr;
    logic [COLOR_W-1:0] w_rdata;

    assign w_we    = (r_state == S_PLOT) && (r_x < FB_WIDTH) && (r_y < FB_HEIGHT);
    assign w_waddr = ADDR_W'(r_y * FB_WIDTH + r_x);
    assign w_re    = (r_state == S_SETUP) && (r_cmd.kind == KIND_READ);
    assign w_raddr = ADDR_W'(c_y * FB_WIDTH + c_x);

    fbre_ram #(.WIDTH(COLOR_W), .DEPTH(FB_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_color),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- plot stepper ----------------
    logic [ACC_W-1:0] w_acc_sum;
    logic             w_minor, w_step_x, w_step_y, w_row_end, w_last;

    assign w_acc_sum = r_acc + ACC_W'(r_slope);
    assign w_minor   = (w_acc_sum > ACC_W'(SLOPE_ONE));
    assign w_step_x  = r_maj_x || w_minor;
    assign w_step_y  = !r_maj_x || w_minor;
    assign w_row_end = (r_i == r_w - CNT_W'(1));
    assign w_last    = w_row_end && (r_j == r_h - CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_cmd_valid) n_state = S_SETUP;
            S_SETUP: begin
                unique case (r_cmd.kind)
                    KIND_READ: n_state = rd_ok ? S_RD : S_FIN;
                    KIND_LINE: n_state = line_rej ? S_FIN : (need_div ? S_DIV : S_PLOT);
                    default:   n_state = rect_rej ? S_FIN : S_PLOT;
                endcase
            end
            S_DIV:   if (w_div_done) n_state = S_PLOT;
            S_PLOT:  if (w_last) n_state = S_FIN;
            S_RD:    n_state = S_FIN;
            S_FIN:   if (!r_res_valid || i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_clip_left <= '0;
            r_clip_top  <= '0;
            r_clip_w    <= 8'd128;
            r_clip_h    <= 8'd128;
            r_fg        <= 24'hFFFFFF;
            r_bg        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && (!r_res_valid || i_res_ready)) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            // configuration write
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CLIP_LEFT:   r_clip_left <= i_cfg_data[6:0];
                    CFG_CLIP_TOP:    r_clip_top  <= i_cfg_data[6:0];
                    CFG_CLIP_WIDTH:  r_clip_w    <= i_cfg_data[7:0];
                    CFG_CLIP_HEIGHT: r_clip_h    <= i_cfg_data[7:0];
                    CFG_FG_COLOR:    r_fg        <= i_cfg_data;
                    CFG_BG_COLOR:    r_bg        <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_SETUP) begin
            r_pix   <= '0;
            r_acc   <= '0;
            r_slope <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_color <= (r_cmd.kind == KIND_CLEAR) ? r_bg : r_fg;
            if (r_cmd.kind == KIND_LINE) begin
                r_rej   <= line_rej;
                r_line  <= 1'b1;
                r_maj_x <= !maj_y;
                r_y_dn  <= lh[CALC_W-1] && !w0;
                r_w     <= line_n;
                r_h     <= CNT_W'(1);
                r_x     <= COORD_W'(lx) + COORD_W'(r_clip_left);
                r_x0    <= COORD_W'(lx) + COORD_W'(r_clip_left);
                r_y     <= COORD_W'((w0 && lh[CALC_W-1]) ? ey : ly) + COORD_W'(r_clip_top);
            end else if (r_cmd.kind == KIND_READ) begin
                r_rej   <= !rd_ok;
                r_line  <= 1'b0;
            end else begin
                r_rej   <= rect_rej;
                r_line  <= 1'b0;
                r_maj_x <= 1'b1;
                r_y_dn  <= 1'b0;
                r_w     <= CNT_W'(rw2);
                r_h     <= CNT_W'(rh2);
                r_x     <= COORD_W'(rx) + COORD_W'(r_clip_left);
                r_x0    <= COORD_W'(rx) + COORD_W'(r_clip_left);
                r_y     <= COORD_W'(ry) + COORD_W'(r_clip_top);
            end
        end
        if (r_state == S_DIV && w_div_done) begin
            r_slope <= w_quo;
        end
        // one pixel per cycle
        if (r_state == S_PLOT) begin
            if (r_line) begin
                r_i   <= r_i + CNT_W'(1);
                r_acc <= w_minor ? w_acc_sum - ACC_W'(SLOPE_ONE) : w_acc_sum;
                if (w_step_x) r_x <= r_x + COORD_W'(1);
                if (w_step_y) r_y <= r_y_dn ? r_y - COORD_W'(1) : r_y + COORD_W'(1);
            end else if (w_row_end) begin
                r_i <= '0;
                r_j <= r_j + CNT_W'(1);
                r_x <= r_x0;
                r_y <= r_y + COORD_W'(1);
            end else begin
                r_i <= r_i + CNT_W'(1);
                r_x <= r_x + COORD_W'(1);
            end
        end
        if (r_state == S_RD) begin
            r_pix <= w_rdata;
        end
        if (r_state == S_FIN && (!r_res_valid || i_res_ready)) begin
            r_res.pixel_value <= r_pix;
            r_res.rejected    <= r_rej;
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `FBRE_ASSERT(a_rej_zero,
        (o_res_valid && o_res.rejected) |-> (o_res.pixel_value == '0),
        "rejected word carries a pixel")
    `FBRE_ASSERT(a_div_state, w_div_done |-> (r_state == S_DIV),
        "divider done outside slope phase")
    `FBRE_ASSERT(a_plot_bounds, (r_state == S_PLOT) |-> ((r_i < r_w) && (r_j < r_h)),
        "plot counter overrun")
    `FBRE_ASSERT_NEXT(a_fin_out, (r_state == S_FIN) && (!r_res_valid || i_res_ready),
        o_res_valid && (r_state == S_IDLE), "result word not posted")

endmodule

// ===== hw/rtl/fbre_ram.sv =====
// ---------------------------------------------------------------------------
// fbre_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module fbre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fbre_div.sv =====
// ---------------------------------------------------------------------------
// fbre_div
// Restoring divider, one quotient bit per cycle, for the line slope.
// ---------------------------------------------------------------------------
`include "framebuffer_line_rect_engine_top_defines.svh"

module fbre_div import fbre_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [SLP_W-1:0] o_quo
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNTD_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0]  r_dvd, n_dvd;
    logic [DEN_W:0]    r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;

    logic [DEN_W:0]    w_rem_sh;
    logic              w_ge;

    // shift in the next dividend bit and trial-subtract
    assign w_rem_sh = {r_rem[DEN_W-1:0], r_dvd[DVD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTD_W'(DVD_W);
            n_dvd  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
            n_dvd = {r_dvd[DVD_W-2:0], w_ge};
            n_cnt = r_cnt - CNTD_W'(1);
            if (r_cnt == CNTD_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd[SLP_W-1:0];

    `FBRE_ASSERT(a_busy_cnt, r_busy |-> (r_cnt != '0), "divider busy with zero count")
    `FBRE_ASSERT_NEXT(a_last_done, r_busy && !i_start && (r_cnt == CNTD_W'(1)), o_done && !r_busy, "divider missed done")

endmodule
